// ===== rtl/core/spbt_pkg.sv =====
// Shared types and codes for the step position / backlash tracker.
// No dependencies; imported by every module of the block.
package spbt_pkg;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REQ_DATA_WIDTH = 32;
   localparam int RSP_DATA_WIDTH = 32;

   typedef enum logic {
      REQ_STEP = 1'b0,
      REQ_LOAD = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FAULT  = 2'd1,
      STATUS_BOUNDS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_BACKLASH_WIDTH = 2'd0,
      REG_MIN_POSITION   = 2'd1,
      REG_MAX_POSITION   = 2'd2
   } reg_index_type;

   typedef struct packed {
      req_kind_type       req_type;
      logic               step_forward;
      logic [6:0]         step_distance;
      logic signed [15:0] new_position;
      logic               motor_fault;
      logic               check_bounds;
   } step_req_type;

   typedef struct packed {
      logic signed [15:0] axis_position;
      logic signed [15:0] backlash_offset;
      logic [7:0]         phase_count;
   } axis_state_type;

   typedef struct packed {
      logic [7:0]         backlash_width;
      logic signed [15:0] min_position;
      logic signed [15:0] max_position;
   } axis_cfg_type;

   typedef struct packed {
      logic signed [15:0] position;
      logic [7:0]         drive_phase;
      status_type         status;
   } step_rsp_type;

endpackage

// ===== rtl/core/step_position_backlash_tracker.sv =====
// Top level of the step position / backlash tracker: channels, CSRs, state.
// Depends on spbt_pkg and spbt_step_calc.
//
//  channel  direction  handshake              payload
//  req_     in         req_tvalid/req_tready  tdata step fields, tuser request kind
//  rsp_     out        rsp_tvalid/rsp_tready  tdata position, phase, status
//  csr_     in         APB write/read         backlash width, min/max position
//
// One beat per cycle sustained while rsp_tready holds; input register, result register.
// The axis state updates in the cycle a beat moves from input to result register,
// so consecutive beats see each other's state with no bubble.
// req_tready drops only while both registers are full and the result is stalled.
// Synchronous reset clears state and valid flags, and loads register defaults.
module step_position_backlash_tracker import spbt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [0] step_forward, [7:1] step_distance, [23:8] new_position,
   // [24] motor_fault, [25] check_bounds, [31:26] zero
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // [0] req_type
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [15:0] position, [23:16] drive_phase, [25:24] status, [31:26] zero
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   axis_cfg_type   cfg_ff;
   axis_cfg_type   cfg_in;
   axis_state_type state_ff;
   axis_state_type state_in;
   step_req_type   item_ff;
   step_req_type   item_in;
   step_rsp_type   rsp_ff;
   step_rsp_type   rsp_in;
   logic           in_valid_ff;
   logic           in_valid_in;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic           advance;
   logic           csr_write;
   reg_index_type  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_BACKLASH_WIDTH: cfg_in.backlash_width = csr_pwdata[7:0];
            REG_MIN_POSITION:   cfg_in.min_position   = csr_pwdata[15:0];
            REG_MAX_POSITION:   cfg_in.max_position   = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_BACKLASH_WIDTH: csr_prdata = {24'd0, cfg_ff.backlash_width};
         REG_MIN_POSITION:   csr_prdata = {16'd0, cfg_ff.min_position};
         REG_MAX_POSITION:   csr_prdata = {16'd0, cfg_ff.max_position};
         default:            csr_prdata = '0;
      endcase
   end

   // handshake: the result register frees as it drains, so a beat can move up
   // in the same cycle that a waiting result is taken
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      item_in.req_type      = req_kind_type'(req_tuser);
      item_in.step_forward  = req_tdata[0];
      item_in.step_distance = req_tdata[7:1];
      item_in.new_position  = req_tdata[23:8];
      item_in.motor_fault   = req_tdata[24];
      item_in.check_bounds  = req_tdata[25];
   end

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   axis_state_type calc_state;
   step_rsp_type   calc_rsp;

   spbt_step_calc u_calc (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .item       (item_ff),
      .next_state (calc_state),
      .rsp        (calc_rsp)
   );

   assign state_in = advance ? calc_state : state_ff;
   assign rsp_in   = advance ? calc_rsp : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.backlash_width <= 8'd0;
         cfg_ff.min_position   <= 16'sh8000;
         cfg_ff.max_position   <= 16'sh7fff;
         state_ff              <= '0;
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) item_ff <= item_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.status, rsp_ff.drive_phase, rsp_ff.position};

   // state only moves when a beat passes into the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("axis state changed without a beat");

   a_fault_no_move: assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.req_type == REQ_STEP && item_ff.motor_fault
      |=> $stable(state_ff))
      else $error("faulted step altered axis state");

   a_offset_disabled: assert property (@(posedge clock) disable iff (reset)
      advance && cfg_ff.backlash_width == 8'd0 |=> $stable(state_ff.backlash_offset))
      else $error("backlash offset moved with compensation off");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("input stalled while pipeline could move");

endmodule

// ===== rtl/core/spbt_step_calc.sv =====
// Next-state and result logic for one step or load beat.
// Depends on spbt_pkg.
module spbt_step_calc import spbt_pkg::*; (
   input  axis_state_type state,
   input  axis_cfg_type   cfg,
   input  step_req_type   item,
   output axis_state_type next_state,
   output step_rsp_type   rsp
);

   always_comb begin
      logic signed [17:0] bo;
      logic signed [17:0] wid;
      logic signed [17:0] step_dist;
      logic signed [17:0] sd;
      logic signed [15:0] axis_sum;
      logic signed [15:0] min_pos;
      logic signed [15:0] max_pos;
      status_type         status;

      next_state = state;
      status     = STATUS_OK;
      bo   = signed'({{2{state.backlash_offset[15]}}, state.backlash_offset});
      wid  = signed'({10'd0, cfg.backlash_width});
      step_dist = signed'({11'd0, item.step_distance});
      sd   = item.step_forward ? step_dist : -step_dist;
      min_pos  = cfg.min_position;
      max_pos  = cfg.max_position;
      axis_sum = state.axis_position;

      if (item.req_type == REQ_LOAD) begin
         next_state.axis_position = item.new_position;
      end else if (item.motor_fault) begin
         status = STATUS_FAULT;
      end else begin
         next_state.phase_count = state.phase_count + sd[7:0];
         if (wid != 18'sd0) begin
            if (bo < 18'sd0 && item.step_forward) begin
               // turning round to forward: slack taken up first
               bo = step_dist;
               sd = step_dist - wid;
               if (sd < 18'sd0) sd = 18'sd0;
            end else if (bo >= wid && !item.step_forward) begin
               bo = wid - step_dist;
               sd = wid - step_dist;
               if (sd > 18'sd0) sd = 18'sd0;
            end else if (bo >= 18'sd0 && bo < wid) begin
               // inside the dead zone, only the overshoot moves the axis
               bo = bo + sd;
               if (bo < 18'sd0) sd = bo;
               else if (bo >= wid) sd = bo - wid;
               else sd = 18'sd0;
            end
            next_state.backlash_offset = bo[15:0];
         end
         axis_sum = state.axis_position + sd[15:0];
         next_state.axis_position = axis_sum;
         if (item.check_bounds && (axis_sum < min_pos || axis_sum > max_pos))
            status = STATUS_BOUNDS;
      end

      rsp.position    = next_state.axis_position;
      rsp.drive_phase = next_state.phase_count;
      rsp.status      = status;
   end

endmodule
